// ===== hw/rtl/tmat_pkg.sv =====
// tmat_pkg: shared types and constants of the autotile mask block
// item opcodes, register indexes, neighbor diamond tables, fsm and control structs
// no dependencies
package tmat_pkg;

  localparam int KIND_W  = 4;
  localparam int MASK_W  = 4;
  localparam int ENTRY_W = KIND_W + MASK_W;
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_SET      = 2'd0,
    OP_AUTOTILE = 2'd1,
    OP_READ     = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  // cells within manhattan distance two of the addressed cell
  // 0 center, 1 up, 2 right, 3 down, 4 left, then the outer ring
  localparam int NCELLS = 13;
  localparam int NTGT   = 5;
  localparam int NSIDE  = 4;

  localparam logic [3:0] GATHER_LAST = 4'd12;
  localparam logic [3:0] WRITE_LAST  = 4'd4;

  localparam logic signed [2:0] CELL_DX [NCELLS] = '{
    3'sd0, 3'sd0, 3'sd1, 3'sd0, -3'sd1,
    3'sd0, 3'sd1, 3'sd2, 3'sd1, 3'sd0, -3'sd1, -3'sd2, -3'sd1
  };
  localparam logic signed [2:0] CELL_DY [NCELLS] = '{
    3'sd0, -3'sd1, 3'sd0, 3'sd1, 3'sd0,
    -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, 3'sd1, 3'sd0, -3'sd1
  };

  // for each remasked cell: cell index of its up, right, down, left neighbor
  localparam logic [3:0] TGT_NBR [NTGT][NSIDE] = '{
    '{4'd1,  4'd2, 4'd3,  4'd4},
    '{4'd5,  4'd6, 4'd0,  4'd12},
    '{4'd6,  4'd7, 4'd8,  4'd0},
    '{4'd0,  4'd8, 4'd9,  4'd10},
    '{4'd12, 4'd0, 4'd10, 4'd11}
  };

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SET,
    ST_LOOKUP,
    ST_GATHER,
    ST_DRAIN,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       load_item;
    logic       gather;
    logic       lookup;
    logic       wr_set;
    logic       wr_tgt;
    logic       out_load;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       center_in;
    logic [1:0] op;
  } sts_t;

endpackage

// ===== hw/rtl/tmat_if.sv =====
// tmat_if: valid/ready channels for items and results
// depends on tmat_pkg for field widths
interface tmat_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       operation;
  logic [tmat_pkg::COORD_W-1:0]     col;
  logic [tmat_pkg::COORD_W-1:0]     row;
  logic [tmat_pkg::KIND_W-1:0]      tile_kind;

  modport source (output valid, output operation, output col, output row,
                  output tile_kind, input ready);
  modport sink   (input valid, input operation, input col, input row,
                  input tile_kind, output ready);
endinterface

interface tmat_out_if;
  logic                             valid;
  logic                             ready;
  logic [tmat_pkg::KIND_W-1:0]      kind_out;
  logic [tmat_pkg::MASK_W-1:0]      mask_out;

  modport source (output valid, output kind_out, output mask_out, input ready);
  modport sink   (input valid, input kind_out, input mask_out, output ready);
endinterface

// ===== hw/rtl/tmat_ram.sv =====
// tmat_ram: generic single-port ram with registered read
// no dependencies
module tmat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tmat_ctrl.sv =====
// tmat_ctrl: sequencer of the autotile block, owns result valid
// depends on tmat_pkg (state_t, cmd_t, sts_t, opcodes)
module tmat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tmat_pkg::sts_t    sts,
  output tmat_pkg::cmd_t    cmd
);

  tmat_pkg::state_t state_r, state_nxt;
  logic [3:0]       step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmat_pkg::ST_CLEAR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmat_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = tmat_pkg::ST_IDLE;
      end
      tmat_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tmat_pkg::ST_DISPATCH;
      end
      tmat_pkg::ST_DISPATCH: begin
        if (!sts.center_in) begin
          state_nxt = tmat_pkg::ST_FINISH;
        end else begin
          unique case (sts.op)
            tmat_pkg::OP_SET:      state_nxt = tmat_pkg::ST_SET;
            tmat_pkg::OP_AUTOTILE: state_nxt = tmat_pkg::ST_GATHER;
            default:               state_nxt = tmat_pkg::ST_LOOKUP;
          endcase
        end
      end
      tmat_pkg::ST_SET:    state_nxt = tmat_pkg::ST_FINISH;
      tmat_pkg::ST_LOOKUP: state_nxt = tmat_pkg::ST_FINISH;
      tmat_pkg::ST_GATHER: begin
        if (step_r == tmat_pkg::GATHER_LAST) state_nxt = tmat_pkg::ST_DRAIN;
      end
      tmat_pkg::ST_DRAIN:  state_nxt = tmat_pkg::ST_WRITE;
      tmat_pkg::ST_WRITE: begin
        if (step_r == tmat_pkg::WRITE_LAST) state_nxt = tmat_pkg::ST_FINISH;
      end
      tmat_pkg::ST_FINISH: begin
        if (slot_free) state_nxt = tmat_pkg::ST_IDLE;
      end
      default: state_nxt = tmat_pkg::ST_CLEAR;
    endcase
  end

  // step counter for the gather and write sweeps
  always_comb begin
    step_nxt = '0;
    if ((state_r == tmat_pkg::ST_GATHER && step_r != tmat_pkg::GATHER_LAST) ||
        (state_r == tmat_pkg::ST_WRITE && step_r != tmat_pkg::WRITE_LAST)) begin
      step_nxt = step_r + 4'd1;
    end
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.idx  = step_r;
    in_ready = 1'b0;
    unique case (state_r)
      tmat_pkg::ST_CLEAR:  cmd.clr = 1'b1;
      tmat_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      tmat_pkg::ST_SET:    cmd.wr_set = 1'b1;
      tmat_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
      tmat_pkg::ST_GATHER: cmd.gather = 1'b1;
      tmat_pkg::ST_WRITE:  cmd.wr_tgt = 1'b1;
      tmat_pkg::ST_FINISH: cmd.out_load = slot_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

endmodule

// ===== hw/rtl/tmat_dpath.sv =====
// tmat_dpath: item and config registers, tile store port, mask logic, result register
// depends on tmat_pkg and tmat_ram
module tmat_dpath #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tmat_pkg::cmd_t                      cmd,
  output tmat_pkg::sts_t                      sts,
  input  logic [1:0]                          in_operation,
  input  logic [tmat_pkg::COORD_W-1:0]        in_col,
  input  logic [tmat_pkg::COORD_W-1:0]        in_row,
  input  logic [tmat_pkg::KIND_W-1:0]         in_tile_kind,
  input  logic                                cfg_wr_en,
  input  logic [tmat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmat_pkg::CFG_W-1:0]          cfg_wdata,
  output logic [tmat_pkg::KIND_W-1:0]         out_kind,
  output logic [tmat_pkg::MASK_W-1:0]         out_mask
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = tmat_pkg::KIND_W;
  localparam int MW    = tmat_pkg::MASK_W;
  localparam int EW    = tmat_pkg::ENTRY_W;
  localparam int CW    = tmat_pkg::CFG_W;

  // configuration
  logic [CW-1:0] grid_w_r, grid_h_r;
  logic [CW-1:0] eff_w, eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= CW'(64);
      grid_h_r <= CW'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tmat_pkg::CFG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
        tmat_pkg::CFG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_w = (grid_w_r == '0) ? CW'(1) :
                 ((32'(grid_w_r) > MAX_COLS) ? CW'(MAX_COLS) : grid_w_r);
  assign eff_h = (grid_h_r == '0) ? CW'(1) :
                 ((32'(grid_h_r) > MAX_ROWS) ? CW'(MAX_ROWS) : grid_h_r);

  // latched item
  logic [1:0]                   op_r;
  logic [tmat_pkg::COORD_W-1:0] col_r, row_r;
  logic [KW-1:0]                kind_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_operation;
      col_r  <= in_col;
      row_r  <= in_row;
      kind_r <= in_tile_kind;
    end
  end

  // diamond cell coordinates and in-grid flags
  logic signed [7:0]        cell_x [tmat_pkg::NCELLS];
  logic signed [7:0]        cell_y [tmat_pkg::NCELLS];
  logic [tmat_pkg::NCELLS-1:0] cell_in;

  always_comb begin
    for (int i = 0; i < tmat_pkg::NCELLS; i++) begin
      cell_x[i]  = $signed({2'b00, col_r}) + 8'(tmat_pkg::CELL_DX[i]);
      cell_y[i]  = $signed({2'b00, row_r}) + 8'(tmat_pkg::CELL_DY[i]);
      cell_in[i] = (cell_x[i] >= 0) && (cell_x[i] < $signed({1'b0, eff_w})) &&
                   (cell_y[i] >= 0) && (cell_y[i] < $signed({1'b0, eff_h}));
    end
  end

  // kinds gathered from the store, one per diamond cell
  logic [KW-1:0] kinds_r [tmat_pkg::NCELLS];
  logic          cap_vld_r;
  logic [3:0]    cap_idx_r;
  logic [EW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= cmd.gather && cell_in[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    cap_idx_r <= cmd.idx;
    if (cap_vld_r) kinds_r[cap_idx_r] <= rdata[EW-1:MW];
  end

  // masks of the five remasked cells; an edge side counts as differing
  logic [MW-1:0] tgt_mask [tmat_pkg::NTGT];

  always_comb begin
    for (int t = 0; t < tmat_pkg::NTGT; t++) begin
      for (int s = 0; s < tmat_pkg::NSIDE; s++) begin
        tgt_mask[t][s] = !cell_in[tmat_pkg::TGT_NBR[t][s]] ||
                         (kinds_r[tmat_pkg::TGT_NBR[t][s]] != kinds_r[t]);
      end
    end
  end

  // store port
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] sel_addr;
  logic [2:0]    tgt;
  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign tgt      = cmd.idx[2:0];
  assign sel_addr = cell_in[cmd.idx] ?
                    AW'(32'(cell_y[cmd.idx][6:0]) * MAX_COLS + 32'(cell_x[cmd.idx][6:0])) :
                    '0;

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = sel_addr;
    mem_wdata = {kinds_r[tgt], tgt_mask[tgt]};
    priority if (cmd.clr) begin
      mem_en    = 1'b1;
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.wr_set) begin
      mem_en    = 1'b1;
      mem_we    = 1'b1;
      mem_wdata = {kind_r, MW'(0)};
    end else if (cmd.wr_tgt) begin
      mem_en = cell_in[tgt];
      mem_we = 1'b1;
    end else if (cmd.gather) begin
      mem_en = cell_in[cmd.idx];
    end else if (cmd.lookup) begin
      mem_en = 1'b1;
    end else begin
      mem_en = 1'b0;
    end
  end

  tmat_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  // result register
  logic [EW-1:0] res_nxt, res_r;

  always_comb begin
    if (!cell_in[0]) begin
      res_nxt = '0;
    end else begin
      unique case (op_r)
        tmat_pkg::OP_SET:      res_nxt = {kind_r, MW'(0)};
        tmat_pkg::OP_AUTOTILE: res_nxt = {kinds_r[0], tgt_mask[0]};
        default:               res_nxt = rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) res_r <= res_nxt;
  end

  assign out_kind = res_r[EW-1:MW];
  assign out_mask = res_r[MW-1:0];

  assign sts.clr_last  = (32'(clr_cnt_r) == DEPTH - 1);
  assign sts.center_in = cell_in[0];
  assign sts.op        = op_r;

endmodule

// ===== hw/rtl/tile_map_autotile_mask_core.sv =====
// tile_map_autotile_mask_core: four-neighbor bitmask autotiling over a tile grid
// set writes the store and read reads it; an off-grid cell skips the store; autotile
// runs a gather sweep over the 13 diamond cells, a drain state and a write sweep over the
// 5 remasked cells; each then loads the result register; the next beat is taken in the
// cycle after that load; a result waiting downstream does not block intake
// reset: synchronous, clears the store one entry a cycle, no intake
module tile_map_autotile_mask_core #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tmat_in_if.sink                             in_bus,
  tmat_out_if.source                          out_bus,
  input  logic                                cfg_wr_en,
  input  logic [tmat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmat_pkg::CFG_W-1:0]          cfg_wdata
);

  // command and status between sequencer and datapath
  tmat_pkg::cmd_t cmd;
  tmat_pkg::sts_t sts;

  // sequencer: clearing sweep, dispatch by opcode, gather/write sweeps, result valid
  tmat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: grid size registers, the tile store, the five-mask compare logic
  // and the result register that holds a beat while the sink stalls
  tmat_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_bus.operation),
    .in_col       (in_bus.col),
    .in_row       (in_bus.row),
    .in_tile_kind (in_bus.tile_kind),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_kind     (out_bus.kind_out),
    .out_mask     (out_bus.mask_out)
  );

endmodule

// ===== hw/rtl/tmat_chk.sv =====
// tmat_chk: port-level checks of the autotile block, bound to the top level
// depends on tile_map_autotile_mask_core ports
module tmat_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] kind_out,
  input logic [3:0] mask_out
);

  // a result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(kind_out) && $stable(mask_out))
    else $error("result payload changed while stalled");

  // one item in flight: intake closes right after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  // store clearing follows reset, so no intake right after it
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("intake open right after reset");

endmodule

bind tile_map_autotile_mask_core tmat_chk u_tmat_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .kind_out  (out_bus.kind_out),
  .mask_out  (out_bus.mask_out)
);
